FILE: hw/rtl/plc_pkg.sv
// plc_pkg: types, constants and helpers shared by the line clipper cells
// depends on nothing; every plc_* module and the core import it
package plc_pkg;

   localparam int CW = 16;              // coordinate width
   localparam int MW = CW + 1;          // delta / distance / magnitude width
   localparam int RW = CW + 2;          // divider remainder width
   localparam int LANES = 4;            // one lane per window edge
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_LOW  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_HIGH = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_LOW  = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_HIGH = 4'd3;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                 visible;
      logic signed [CW-1:0] clipped_start_x;
      logic signed [CW-1:0] clipped_start_y;
      logic signed [CW-1:0] clipped_end_x;
      logic signed [CW-1:0] clipped_end_y;
   } rsp_type;

   typedef struct packed {
      logic dir_neg;
      logic dir_pos;
      logic dist_neg;
      logic dist_pos;
   } edge_flag_type;

   typedef struct packed {
      logic signed [CW-1:0] x0;
      logic signed [CW-1:0] y0;
      logic signed [MW-1:0] dx;
      logic signed [MW-1:0] dy;
      edge_flag_type [LANES-1:0] flags;
   } geom_type;

   function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] v);
      mag_of = v[MW-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

FILE: hw/rtl/parametric_line_clipper_core.sv
// parametric_line_clipper_core: segment clipper against a window of four registers
// depends on plc_pkg and the plc_* cells
//
//  channel | ports                                  | word
//  --------+----------------------------------------+------------------------
//  req     | req_valid, req_stall, req_data         | segment endpoints in
//  rsp     | rsp_valid, rsp_stall, rsp_data         | visible flag, endpoints
//  csr     | csr_write_enable, csr_index, csr_data  | window edge write
//
// one segment per cycle sustained while rsp_stall stays low; each word passes the prep
// cell, the row of divider cells (one quotient bit per cell), then the test,
// multiply and sum cells
// each cell holds its word while the next one stalls, so bubbles close up and
// the input keeps taking words until every cell is full
// synchronous reset empties all cells and clears the window registers to zero
module parametric_line_clipper_core #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  plc_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output plc_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [plc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [plc_pkg::CW-1:0]                csr_data
);
   import plc_pkg::*;

   localparam int F = FRACTION_BITS;
   localparam int ND = F + 1;

   logic [3:0][CW-1:0] clip_ff, clip_in;

   always_comb begin
      clip_in = clip_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_X_LOW:  clip_in[CSR_X_LOW]  = csr_data;
            CSR_X_HIGH: clip_in[CSR_X_HIGH] = csr_data;
            CSR_Y_LOW:  clip_in[CSR_Y_LOW]  = csr_data;
            CSR_Y_HIGH: clip_in[CSR_Y_HIGH] = csr_data;
            default:    clip_in = clip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= '0;
      end else begin
         clip_ff <= clip_in;
      end
   end

   // divider row taps: index 0 is the prep cell output
   logic               d_valid [ND+1];
   logic               d_stall [ND+1];
   geom_type           d_geom  [ND+1];
   logic [3:0][RW-1:0] d_rem   [ND+1];
   logic [3:0][MW-1:0] d_den   [ND+1];
   logic [3:0]         d_sat   [ND+1];
   logic [3:0][F:0]    d_quo   [ND+1];

   plc_prep_cell #(.FRAC(F)) u_prep (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall), .in_data(req_data),
      .clip(clip_ff),
      .out_valid(d_valid[0]), .out_stall(d_stall[0]), .out_geom(d_geom[0]),
      .out_rem(d_rem[0]), .out_den(d_den[0]), .out_sat(d_sat[0]),
      .out_quo(d_quo[0])
   );

   for (genvar j = 0; j < ND; j++) begin : g_div
      plc_div_cell #(.FRAC(F), .BIT(F - j)) u_div (
         .clock, .reset,
         .in_valid(d_valid[j]), .in_stall(d_stall[j]), .in_geom(d_geom[j]),
         .in_rem(d_rem[j]), .in_den(d_den[j]), .in_sat(d_sat[j]),
         .in_quo(d_quo[j]),
         .out_valid(d_valid[j+1]), .out_stall(d_stall[j+1]),
         .out_geom(d_geom[j+1]), .out_rem(d_rem[j+1]), .out_den(d_den[j+1]),
         .out_sat(d_sat[j+1]), .out_quo(d_quo[j+1])
      );
   end

   logic          t_valid, t_stall, t_ok;
   geom_type      t_geom;
   logic [F:0]    t_t0, t_t1;

   plc_test_cell #(.FRAC(F)) u_test (
      .clock, .reset,
      .in_valid(d_valid[ND]), .in_stall(d_stall[ND]), .in_geom(d_geom[ND]),
      .in_sat(d_sat[ND]), .in_quo(d_quo[ND]),
      .out_valid(t_valid), .out_stall(t_stall), .out_geom(t_geom),
      .out_ok(t_ok), .out_t0(t_t0), .out_t1(t_t1)
   );

   logic                  m_valid, m_stall, m_ok;
   geom_type              m_geom;
   logic [3:0][MW+F:0]    m_prod;

   plc_mult_cell #(.FRAC(F)) u_mult (
      .clock, .reset,
      .in_valid(t_valid), .in_stall(t_stall), .in_geom(t_geom),
      .in_ok(t_ok), .in_t0(t_t0), .in_t1(t_t1),
      .out_valid(m_valid), .out_stall(m_stall), .out_geom(m_geom),
      .out_ok(m_ok), .out_prod(m_prod)
   );

   plc_sum_cell #(.FRAC(F)) u_sum (
      .clock, .reset,
      .in_valid(m_valid), .in_stall(m_stall), .in_geom(m_geom),
      .in_ok(m_ok), .in_prod(m_prod),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp_data)
   );

   // rejected words carry zero coordinates
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.visible) |->
         (rsp_data.clipped_start_x == '0) && (rsp_data.clipped_start_y == '0) &&
         (rsp_data.clipped_end_x == '0) && (rsp_data.clipped_end_y == '0))
      else $error("rejected word with nonzero coordinates");

   // input backs up only when the whole row is full behind a stalled output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled output");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

FILE: hw/rtl/plc_prep_cell.sv
// plc_prep_cell: first cell, forms deltas, edge distances and divider operands
// depends on plc_pkg
module plc_prep_cell #(
   parameter int FRAC = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_stall,
   input  plc_pkg::req_type                        in_data,
   input  logic [3:0][plc_pkg::CW-1:0]             clip,
   output logic                                    out_valid,
   input  logic                                    out_stall,
   output plc_pkg::geom_type                       out_geom,
   output logic [3:0][plc_pkg::RW-1:0]             out_rem,
   output logic [3:0][plc_pkg::MW-1:0]             out_den,
   output logic [3:0]                              out_sat,
   output logic [3:0][FRAC:0]                      out_quo
);
   import plc_pkg::*;

   logic                 load;
   logic                 valid_ff, valid_in;
   geom_type             geom_ff, geom_in;
   logic [3:0][RW-1:0]   rem_ff, rem_in;
   logic [3:0][MW-1:0]   den_ff, den_in;
   logic [3:0]           sat_ff, sat_in;
   logic signed [MW-1:0] x0, y0, x1, y1, xl, xr, yl, yh;
   logic signed [MW-1:0] dir [LANES];
   logic signed [MW-1:0] span [LANES];
   logic [MW-1:0]        a, b;

   always_comb begin
      x0 = {in_data.start_x[CW-1], in_data.start_x};
      y0 = {in_data.start_y[CW-1], in_data.start_y};
      x1 = {in_data.end_x[CW-1], in_data.end_x};
      y1 = {in_data.end_y[CW-1], in_data.end_y};
      xl = {clip[CSR_X_LOW][CW-1], clip[CSR_X_LOW]};
      xr = {clip[CSR_X_HIGH][CW-1], clip[CSR_X_HIGH]};
      yl = {clip[CSR_Y_LOW][CW-1], clip[CSR_Y_LOW]};
      yh = {clip[CSR_Y_HIGH][CW-1], clip[CSR_Y_HIGH]};
      geom_in.x0 = in_data.start_x;
      geom_in.y0 = in_data.start_y;
      geom_in.dx = x1 - x0;
      geom_in.dy = y1 - y0;
      dir[0] = -geom_in.dx;  span[0] = x0 - xl;
      dir[1] = geom_in.dx;   span[1] = xr - x0;
      dir[2] = -geom_in.dy;  span[2] = y0 - yl;
      dir[3] = geom_in.dy;   span[3] = yh - y0;
      for (int i = 0; i < LANES; i++) begin
         a = mag_of(span[i]);
         b = mag_of(dir[i]);
         geom_in.flags[i].dir_neg  = dir[i][MW-1];
         geom_in.flags[i].dir_pos  = !dir[i][MW-1] && (dir[i] != '0);
         geom_in.flags[i].dist_neg = span[i][MW-1];
         geom_in.flags[i].dist_pos = !span[i][MW-1] && (span[i] != '0);
         // quotient at or above two saturates; a zero divisor lands here too
         sat_in[i] = {1'b0, a} >= {b, 1'b0};
         rem_in[i] = {1'b0, a};
         den_in[i] = b;
      end
   end

   always_comb begin
      load     = !(valid_ff && out_stall);
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         geom_ff <= geom_in;
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         sat_ff  <= sat_in;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_geom  = geom_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_sat   = sat_ff;
   assign out_quo   = '0;

endmodule

FILE: hw/rtl/plc_div_cell.sv
// plc_div_cell: one restoring-division step for each of the four window-boundary lanes
// depends on plc_pkg; a row of these settles one quotient bit per cell
module plc_div_cell #(
   parameter int FRAC = 16,
   parameter int BIT  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  plc_pkg::geom_type           in_geom,
   input  logic [3:0][plc_pkg::RW-1:0] in_rem,
   input  logic [3:0][plc_pkg::MW-1:0] in_den,
   input  logic [3:0]                  in_sat,
   input  logic [3:0][FRAC:0]          in_quo,
   output logic                        out_valid,
   input  logic                        out_stall,
   output plc_pkg::geom_type           out_geom,
   output logic [3:0][plc_pkg::RW-1:0] out_rem,
   output logic [3:0][plc_pkg::MW-1:0] out_den,
   output logic [3:0]                  out_sat,
   output logic [3:0][FRAC:0]          out_quo
);
   import plc_pkg::*;

   localparam bit FIRST = (BIT == FRAC);

   logic               load;
   logic               valid_ff, valid_in;
   geom_type           geom_ff;
   logic [3:0][RW-1:0] rem_ff, rem_in;
   logic [3:0][MW-1:0] den_ff;
   logic [3:0]         sat_ff;
   logic [3:0][FRAC:0] quo_ff, quo_in;
   logic [RW-1:0]      r_sh;
   logic               ge;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         // remainder stays below the divisor, so the shift never overflows
         r_sh      = FIRST ? in_rem[i] : {in_rem[i][RW-2:0], 1'b0};
         ge        = r_sh >= {1'b0, in_den[i]};
         rem_in[i] = ge ? r_sh - {1'b0, in_den[i]} : r_sh;
         quo_in[i] = in_quo[i];
         quo_in[i][BIT] = ge;
      end
   end

   always_comb begin
      load     = !(valid_ff && out_stall);
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         geom_ff <= in_geom;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         sat_ff  <= in_sat;
         quo_ff  <= quo_in;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_geom  = geom_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_sat   = sat_ff;
   assign out_quo   = quo_ff;

endmodule

FILE: hw/rtl/plc_test_cell.sv
// plc_test_cell: clamps the quotients and runs the four boundary tests in order
// depends on plc_pkg
module plc_test_cell #(
   parameter int FRAC = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  plc_pkg::geom_type  in_geom,
   input  logic [3:0]         in_sat,
   input  logic [3:0][FRAC:0] in_quo,
   output logic               out_valid,
   input  logic               out_stall,
   output plc_pkg::geom_type  out_geom,
   output logic               out_ok,
   output logic [FRAC:0]      out_t0,
   output logic [FRAC:0]      out_t1
);
   import plc_pkg::*;

   localparam logic [FRAC:0] T_ONE = {1'b1, {FRAC{1'b0}}};
   localparam logic [FRAC:0] T_SAT = T_ONE + 1'b1;

   logic          load;
   logic          valid_ff, valid_in;
   geom_type      geom_ff;
   logic          ok_ff, ok_in;
   logic [FRAC:0] t0_ff, t0_in, t1_ff, t1_in;
   logic [FRAC:0] r;

   always_comb begin
      ok_in = 1'b1;
      t0_in = '0;
      t1_in = T_ONE;
      for (int i = 0; i < LANES; i++) begin
         r = (in_sat[i] || (in_quo[i] > T_SAT)) ? T_SAT : in_quo[i];
         if (in_geom.flags[i].dir_neg) begin
            // positive distance means a negative quotient: no change
            if (!in_geom.flags[i].dist_pos) begin
               if (r > t1_in) begin
                  ok_in = 1'b0;
               end else if (r > t0_in) begin
                  t0_in = r;
               end
            end
         end else if (in_geom.flags[i].dir_pos) begin
            if (in_geom.flags[i].dist_neg || (r < t0_in)) begin
               ok_in = 1'b0;
            end else if (r < t1_in) begin
               t1_in = r;
            end
         end else if (in_geom.flags[i].dist_neg) begin
            ok_in = 1'b0;
         end
      end
   end

   always_comb begin
      load     = !(valid_ff && out_stall);
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         geom_ff <= in_geom;
         ok_ff   <= ok_in;
         t0_ff   <= t0_in;
         t1_ff   <= t1_in;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_geom  = geom_ff;
   assign out_ok    = ok_ff;
   assign out_t0    = t0_ff;
   assign out_t1    = t1_ff;

endmodule

FILE: hw/rtl/plc_mult_cell.sv
// plc_mult_cell: magnitude of delta times parameter for the four coordinates
// depends on plc_pkg
module plc_mult_cell #(
   parameter int FRAC = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_stall,
   input  plc_pkg::geom_type                      in_geom,
   input  logic                                   in_ok,
   input  logic [FRAC:0]                          in_t0,
   input  logic [FRAC:0]                          in_t1,
   output logic                                   out_valid,
   input  logic                                   out_stall,
   output plc_pkg::geom_type                      out_geom,
   output logic                                   out_ok,
   output logic [3:0][plc_pkg::MW+FRAC:0]         out_prod
);
   import plc_pkg::*;

   localparam int PW = MW + FRAC + 1;

   logic               load;
   logic               valid_ff, valid_in;
   geom_type           geom_ff;
   logic               ok_ff;
   logic [3:0][PW-1:0] prod_ff, prod_in;
   logic [MW-1:0]      mdx, mdy;

   always_comb begin
      mdx = mag_of(in_geom.dx);
      mdy = mag_of(in_geom.dy);
      // lane order: start x, start y, end x, end y
      prod_in[0] = PW'(mdx) * PW'(in_t0);
      prod_in[1] = PW'(mdy) * PW'(in_t0);
      prod_in[2] = PW'(mdx) * PW'(in_t1);
      prod_in[3] = PW'(mdy) * PW'(in_t1);
   end

   always_comb begin
      load     = !(valid_ff && out_stall);
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         geom_ff <= in_geom;
         ok_ff   <= in_ok;
         prod_ff <= prod_in;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_geom  = geom_ff;
   assign out_ok    = ok_ff;
   assign out_prod  = prod_ff;

endmodule

FILE: hw/rtl/plc_sum_cell.sv
// plc_sum_cell: last cell, adds the scaled start and truncates toward zero
// depends on plc_pkg; its register is the result word register
module plc_sum_cell #(
   parameter int FRAC = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  plc_pkg::geom_type              in_geom,
   input  logic                           in_ok,
   input  logic [3:0][plc_pkg::MW+FRAC:0] in_prod,
   output logic                           out_valid,
   input  logic                           out_stall,
   output plc_pkg::rsp_type               out_data
);
   import plc_pkg::*;

   localparam int NW = CW + FRAC + 3;
   localparam int PW = MW + FRAC + 1;

   logic                 load;
   logic                 valid_ff, valid_in;
   rsp_type              data_ff, data_in;
   logic signed [CW-1:0] s;
   logic                 dneg;
   logic [NW-1:0]        base, pm, n, mn;
   logic [CW-1:0]        q;
   logic [3:0][CW-1:0]   coord;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         s    = i[0] ? in_geom.y0 : in_geom.x0;
         dneg = i[0] ? in_geom.dy[MW-1] : in_geom.dx[MW-1];
         base = {{(NW-CW){s[CW-1]}}, s} << FRAC;
         pm   = {{(NW-PW){1'b0}}, in_prod[i]};
         n    = dneg ? base - pm : base + pm;
         mn   = n[NW-1] ? (~n + 1'b1) : n;
         q    = mn[FRAC +: CW];
         coord[i] = n[NW-1] ? (~q + 1'b1) : q;
      end
      data_in.visible         = in_ok;
      data_in.clipped_start_x = in_ok ? coord[0] : '0;
      data_in.clipped_start_y = in_ok ? coord[1] : '0;
      data_in.clipped_end_x   = in_ok ? coord[2] : '0;
      data_in.clipped_end_y   = in_ok ? coord[3] : '0;
   end

   always_comb begin
      load     = !(valid_ff && out_stall);
      valid_in = load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: tb/tb_parametric_line_clipper_core.sv
// testbench for parametric_line_clipper_core: clipped segments checked against a local predictor
// depends on plc_pkg and the core; random idling on both channels, window changed between phases
`timescale 1ns / 1ps

module tb_parametric_line_clipper_core;
   import plc_pkg::*;

   localparam int FB = 16;
   localparam int LATENCY = FB + 5;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint T_ONE = 64'sd1 << FB;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_X_LOW;
   logic [CW-1:0] csr_data = '0;

   parametric_line_clipper_core #(.FRACTION_BITS(FB)) DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // window as the predictor sees it
   longint win_xl, win_xr, win_yl, win_yh;
   req_type segment_queue[$];
   rsp_type clipped_queue[$];
   int error_count = 0;
   int segments_sent = 0, visible_seen = 0, rejected_seen = 0, windows_used = 0;
   int idle_cycles = 0;
   bit hold_sender = 0;

   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type want);
      error_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
   endtask

   function automatic longint quotient_of(longint gap, longint dir);
      longint ad, ar, r;
      ad = gap < 0 ? -gap : gap;
      ar = dir < 0 ? -dir : dir;
      r = (ad << FB) / ar;
      return r > T_ONE + 1 ? T_ONE + 1 : r;
   endfunction

   function automatic bit narrow_range(longint dir, longint gap, ref longint t0,
                                       ref longint t1);
      longint r;
      if (dir < 0) begin
         if (gap > 0) return 1;
         r = quotient_of(gap, dir);
         if (r > t1) return 0;
         if (r > t0) t0 = r;
      end else if (dir > 0) begin
         if (gap < 0) return 0;
         r = quotient_of(gap, dir);
         if (r < t0) return 0;
         if (r < t1) t1 = r;
      end else if (gap < 0) begin
         return 0;
      end
      return 1;
   endfunction

   function automatic logic [CW-1:0] point_on_line(longint s, longint d, longint t);
      longint n, q;
      n = s * T_ONE + d * t;
      q = (n < 0 ? -n : n) >>> FB;
      q = n < 0 ? -q : q;
      return q[CW-1:0];
   endfunction

   function automatic rsp_type clip_segment(req_type seg);
      rsp_type r;
      longint x0, y0, dx, dy, t0, t1;
      bit ok;
      x0 = longint'(seg.start_x);
      y0 = longint'(seg.start_y);
      dx = longint'(seg.end_x) - x0;
      dy = longint'(seg.end_y) - y0;
      t0 = 0;
      t1 = T_ONE;
      ok = narrow_range(-dx, x0 - win_xl, t0, t1)
        && narrow_range(dx, win_xr - x0, t0, t1)
        && narrow_range(-dy, y0 - win_yl, t0, t1)
        && narrow_range(dy, win_yh - y0, t0, t1);
      r = '0;
      if (ok) begin
         r.visible = 1'b1;
         r.clipped_start_x = point_on_line(x0, dx, t0);
         r.clipped_start_y = point_on_line(y0, dy, t0);
         r.clipped_end_x = point_on_line(x0, dx, t1);
         r.clipped_end_y = point_on_line(y0, dy, t1);
      end
      return r;
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            clipped_queue.push_back(clip_segment(req_data));
            segments_sent++;
            send_gap = $urandom_range(0, 4);
         end
         if (req_valid && req_stall) begin
            // hold word
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!hold_sender && segment_queue.size() > 0) begin
            req_data <= segment_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   int stall_gap = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (clipped_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_data, '0);
            end else begin
               want = clipped_queue.pop_front();
               if (rsp_data.visible) visible_seen++; else rejected_seen++;
               if (rsp_data.visible !== want.visible)
                  report_mismatch("visible", rsp_data, want);
               if (rsp_data.clipped_start_x !== want.clipped_start_x)
                  report_mismatch("clipped_start_x", rsp_data, want);
               if (rsp_data.clipped_start_y !== want.clipped_start_y)
                  report_mismatch("clipped_start_y", rsp_data, want);
               if (rsp_data.clipped_end_x !== want.clipped_end_x)
                  report_mismatch("clipped_end_x", rsp_data, want);
               if (rsp_data.clipped_end_y !== want.clipped_end_y)
                  report_mismatch("clipped_end_y", rsp_data, want);
            end
            stall_gap = $urandom_range(0, 4);
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [CW-1:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return $urandom_range(0, 1) ? 16'(win_xl) : 16'(win_yh);
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic push_segment(input int sx, input int sy, input int ex, input int ey);
      req_type s;
      s.start_x = sx[CW-1:0];
      s.start_y = sy[CW-1:0];
      s.end_x = ex[CW-1:0];
      s.end_y = ey[CW-1:0];
      segment_queue.push_back(s);
   endtask

   // sampled away from the rising edge so driver updates are settled
   task automatic drain();
      while (segment_queue.size() > 0 || req_valid || clipped_queue.size() > 0)
         @(negedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_window(input int xl, input int xr, input int yl, input int yh);
      logic [CW-1:0] v[4];
      logic [CSR_INDEX_WIDTH-1:0] idx[4];
      v = '{xl[CW-1:0], xr[CW-1:0], yl[CW-1:0], yh[CW-1:0]};
      idx = '{CSR_X_LOW, CSR_X_HIGH, CSR_Y_LOW, CSR_Y_HIGH};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_data <= v[i];
         @(posedge clock);
      end
      // out of range index is ignored
      csr_index <= 4'd9;
      csr_data <= CW'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      win_xl = longint'($signed(v[0]));
      win_xr = longint'($signed(v[1]));
      win_yl = longint'($signed(v[2]));
      win_yh = longint'($signed(v[3]));
      windows_used++;
   endtask

   task automatic random_window();
      int a, b, c, d;
      a = int'($signed(16'($urandom)));
      b = int'($signed(16'($urandom)));
      c = int'($signed(16'($urandom)));
      d = int'($signed(16'($urandom)));
      if ($urandom_range(0, 7) != 0) begin
         if (a > b) begin int t = a; a = b; b = t; end
         if (c > d) begin int t = c; c = d; d = t; end
      end
      set_window(a, b, c, d);
   endtask

   initial begin
      win_xl = 0; win_xr = 0; win_yl = 0; win_yh = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset window is a single point at the origin
      push_segment(0, 0, 0, 0);
      push_segment(1, 0, 1, 0);
      push_segment(-5, 0, 5, 0);
      drain();
      set_window(-100, 100, -50, 50);
      push_segment(0, 0, 10, 10);          // fully inside
      push_segment(-200, 0, 200, 0);       // crosses both x bounds
      push_segment(0, -300, 0, 300);       // vertical, crosses the y bounds
      push_segment(-200, 60, 200, 60);     // horizontal above window
      push_segment(300, 300, 400, 400);    // outside
      push_segment(100, 50, 100, 50);      // point on corner
      push_segment(101, 0, 101, 0);        // point just outside
      push_segment(-200, -200, 200, 200);  // diagonal
      push_segment(200, 200, -200, -200);  // reversed
      push_segment(-32768, -32768, 32767, 32767);
      push_segment(32767, -32768, -32768, 32767);
      push_segment(-32768, 0, -32768, 0);
      drain();
      set_window(-32768, 32767, -32768, 32767);
      push_segment(-32768, -32768, 32767, 32767);
      push_segment(32767, 32767, -32768, -32768);
      push_segment(-32768, 32767, 32767, -32768);
      drain();
      set_window(100, -100, 50, -50);      // inverted window
      push_segment(0, 0, 10, 10);
      push_segment(-200, 0, 200, 0);
      drain();
      for (int phase = 0; phase < 12; phase++) begin
         random_window();
         for (int n = 0; n < 150; n++)
            segment_queue.push_back('{random_coord(), random_coord(),
                                       random_coord(), random_coord()});
         if (phase == 5) begin
            // sender holds off until the pipe is empty
            while (segment_queue.size() > 75) @(negedge clock);
            hold_sender = 1;
            while (req_valid || clipped_queue.size() > 0) @(negedge clock);
            hold_sender = 0;
         end
         // a stretch with no rsp-side stall pressure relief is left to chance
         drain();
      end
      set_window(32767, 32767, -32768, -32768);
      for (int n = 0; n < 20; n++)
         segment_queue.push_back('{random_coord(), random_coord(),
                                    random_coord(), random_coord()});
      drain();
      $display("sent %0d segments over %0d windows: %0d visible, %0d rejected",
               segments_sent, windows_used, visible_seen, rejected_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_prep_cell.sv
hw/rtl/plc_div_cell.sv
hw/rtl/plc_test_cell.sv
hw/rtl/plc_mult_cell.sv
hw/rtl/plc_sum_cell.sv
hw/rtl/parametric_line_clipper_core.sv
tb/tb_parametric_line_clipper_core.sv
